>>> rtl/ulcp_pkg.sv
// shared constants, types and matcher function for the line command parser
package ulcp_pkg;

   localparam int LINE_BUF   = 64;
   localparam int LEN_W      = $clog2(LINE_BUF);
   localparam int BANK_DEPTH = 2 * LINE_BUF;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);

   localparam int REQ_TYPE_W = 2;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 6;
   localparam int CMD_W      = 3;
   localparam int SAVED_W    = 6;
   localparam int CMP_W      = (LEN_W > IDX_W) ? LEN_W : IDX_W;

   localparam int PAT_LEN    = 9;
   localparam int PROG_W     = $clog2(PAT_LEN);

   typedef logic [CHAR_W-1:0] char_type;

   localparam logic [REQ_TYPE_W-1:0] REQ_BYTE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TAKE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ = 2'd2;

   localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SENS_1  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CAL_MIN = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CAL_MAX = 3'd5;

   localparam char_type CHAR_NUL     = 8'h00;
   localparam char_type CHAR_NEWLINE = 8'h0A;
   localparam char_type CHAR_SENS_LO = 8'h31;
   localparam char_type CHAR_SENS_HI = 8'h33;
   localparam char_type CHAR_OPEN    = 8'h3C;

   localparam char_type PAT_MIN [PAT_LEN] = '{
      8'h3C, 8'h43, 8'h41, 8'h4C, 8'h3A, 8'h4D, 8'h49, 8'h4E, 8'h3E};
   localparam char_type PAT_MAX [PAT_LEN] = '{
      8'h3C, 8'h43, 8'h41, 8'h4C, 8'h3A, 8'h4D, 8'h41, 8'h58, 8'h3E};

   typedef struct packed {
      logic              hit;
      logic [PROG_W-1:0] prog;
   } match_type;

   // advance one pattern matcher by one byte
   function automatic match_type match_next(input logic is_max,
                                            input logic [PROG_W-1:0] prog,
                                            input char_type b);
      match_type res;
      char_type  pc;
      pc       = is_max ? PAT_MAX[prog] : PAT_MIN[prog];
      res.hit  = 1'b0;
      res.prog = '0;
      if (pc == b) begin
         if (prog == PROG_W'(PAT_LEN - 1)) begin
            res.hit = 1'b1;
         end else begin
            res.prog = prog + PROG_W'(1);
         end
      end else if (b == CHAR_OPEN) begin
         res.prog = PROG_W'(1);
      end
      return res;
   endfunction

endpackage

>>> rtl/ulcp_req_if.sv
// request channel: valid/ready with byte, take and read requests
interface ulcp_req_if import ulcp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   char_type              rx_byte;
   logic [IDX_W-1:0]      read_index;

   modport source (output valid, output req_type, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input req_type, input rx_byte, input read_index,
                   output ready);
endinterface

>>> rtl/ulcp_rsp_if.sv
// response channel: valid/ready with command, line byte and saved length
interface ulcp_rsp_if import ulcp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   char_type           line_char;
   logic [SAVED_W-1:0] saved_length;

   modport source (output valid, output command, output line_char, output saved_length,
                   input ready);
   modport sink   (input valid, input command, input line_char, input saved_length,
                   output ready);
endinterface

>>> rtl/uart_line_command_parser_core.sv
// line command parser: one beat in per cycle while not stalled, one response beat out per request
// the response beat is registered and is valid in the cycle after its request beat is accepted
// throughput: one request beat every cycle, unless a held response is waiting to be taken
// the response register stalls the request side only while a held response is not taken
// reset (synchronous) clears the line gatherer, pending command, bank select and length
// line bank ram is not cleared; reads beyond the saved length return zero
module uart_line_command_parser_core import ulcp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ulcp_req_if.sink     req_chan,
   ulcp_rsp_if.source   rsp_chan
);
   logic              accept;
   logic              byte_beat;
   logic              read_beat;
   logic              end_line;
   match_type         min_step;
   match_type         max_step;

   logic [PROG_W-1:0] min_prog_ff, min_prog_in;
   logic [PROG_W-1:0] max_prog_ff, max_prog_in;
   logic              min_found_ff, min_found_in;
   logic              max_found_ff, max_found_in;
   logic              zero_seen_ff, zero_seen_in;
   logic [LEN_W-1:0]  line_count_ff, line_count_in;
   logic [LEN_W-1:0]  content_ff, content_in;
   logic [CMD_W-1:0]  pending_ff, pending_in;
   logic              front_ff, front_in;
   logic [LEN_W-1:0]  stored_ff, stored_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic              char_ok_ff, char_ok_in;
   logic [SAVED_W-1:0] saved_ff, saved_in;

   char_type          ram_q;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;
   assign byte_beat = accept && (req_chan.req_type == REQ_BYTE);
   assign read_beat = accept && (req_chan.req_type == REQ_READ);

   assign min_step = match_next(1'b0, min_prog_ff, req_chan.rx_byte);
   assign max_step = match_next(1'b1, max_prog_ff, req_chan.rx_byte);
   assign end_line = (req_chan.rx_byte == CHAR_NEWLINE)
                     || (line_count_ff == LEN_W'(LINE_BUF - 2));

   ulcp_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BANK_DEPTH)
   ) u_bank_ram (
      .clock   (clock),
      .wr_en   (byte_beat),
      .wr_addr ({~front_ff, line_count_ff}),
      .wr_data (req_chan.rx_byte),
      .rd_en   (read_beat),
      .rd_addr ({front_ff, LEN_W'(req_chan.read_index)}),
      .rd_data (ram_q)
   );

   always_comb begin
      min_prog_in   = min_prog_ff;
      max_prog_in   = max_prog_ff;
      min_found_in  = min_found_ff;
      max_found_in  = max_found_ff;
      zero_seen_in  = zero_seen_ff;
      line_count_in = line_count_ff;
      content_in    = content_ff;
      pending_in    = pending_ff;
      front_in      = front_ff;
      stored_in     = stored_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      cmd_in        = cmd_ff;
      char_ok_in    = char_ok_ff;
      saved_in      = saved_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         cmd_in       = CMD_NONE;
         char_ok_in   = 1'b0;
         case (req_chan.req_type)
            REQ_BYTE: begin
               if (req_chan.rx_byte >= CHAR_SENS_LO && req_chan.rx_byte <= CHAR_SENS_HI) begin
                  pending_in = CMD_SENS_1 + CMD_W'(req_chan.rx_byte - CHAR_SENS_LO);
               end
               line_count_in = line_count_ff + LEN_W'(1);
               if (!zero_seen_ff) begin
                  if (req_chan.rx_byte == CHAR_NUL) begin
                     zero_seen_in = 1'b1;
                  end else begin
                     content_in   = content_ff + LEN_W'(1);
                     min_prog_in  = min_step.prog;
                     max_prog_in  = max_step.prog;
                     min_found_in = min_found_ff || min_step.hit;
                     max_found_in = max_found_ff || max_step.hit;
                  end
               end
               if (end_line) begin
                  if (min_found_in) begin
                     pending_in = CMD_CAL_MIN;
                  end else if (max_found_in) begin
                     pending_in = CMD_CAL_MAX;
                  end else begin
                     front_in  = ~front_ff;
                     stored_in = content_in;
                  end
                  min_prog_in   = '0;
                  max_prog_in   = '0;
                  min_found_in  = 1'b0;
                  max_found_in  = 1'b0;
                  zero_seen_in  = 1'b0;
                  line_count_in = '0;
                  content_in    = '0;
               end
            end
            REQ_TAKE: begin
               cmd_in     = pending_ff;
               pending_in = CMD_NONE;
            end
            REQ_READ: begin
               char_ok_in = (CMP_W'(req_chan.read_index) < CMP_W'(stored_ff))
                            && ((CMP_W + 1)'(req_chan.read_index) < (CMP_W + 1)'(LINE_BUF));
            end
            default: begin
            end
         endcase
         saved_in = SAVED_W'(stored_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_prog_ff   <= '0;
         max_prog_ff   <= '0;
         min_found_ff  <= 1'b0;
         max_found_ff  <= 1'b0;
         zero_seen_ff  <= 1'b0;
         line_count_ff <= '0;
         content_ff    <= '0;
         pending_ff    <= CMD_NONE;
         front_ff      <= 1'b0;
         stored_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_prog_ff   <= min_prog_in;
         max_prog_ff   <= max_prog_in;
         min_found_ff  <= min_found_in;
         max_found_ff  <= max_found_in;
         zero_seen_ff  <= zero_seen_in;
         line_count_ff <= line_count_in;
         content_ff    <= content_in;
         pending_ff    <= pending_in;
         front_ff      <= front_in;
         stored_ff     <= stored_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      char_ok_ff <= char_ok_in;
      saved_ff   <= saved_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.command      = cmd_ff;
   assign rsp_chan.line_char    = char_ok_ff ? ram_q : CHAR_NUL;
   assign rsp_chan.saved_length = saved_ff;
endmodule

>>> rtl/ulcp_ram.sv
// generic single write port ram with registered read
module ulcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> dv/testbench.sv
// self-checking testbench for the uart line command parser core
module testbench import ulcp_pkg::*; ();

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int PAUSE_AT     = 260;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      char_type              rx_byte;
      logic [IDX_W-1:0]      read_index;
   } req_beat_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      char_type           line_char;
      logic [SAVED_W-1:0] saved_length;
   } rsp_beat_type;

   typedef struct {
      req_beat_type req;
      bit           typed;
      rsp_beat_type rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   ulcp_req_if req_if ();
   ulcp_rsp_if rsp_if ();

   uart_line_command_parser_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always #4 clock = ~clock;

   // parser state as seen from outside
   int               min_prog = 0;
   int               max_prog = 0;
   bit               min_hit = 1'b0;
   bit               max_hit = 1'b0;
   bit               nul_seen = 1'b0;
   int               line_fill = 0;
   int               text_len = 0;
   logic [CMD_W-1:0] held_cmd = CMD_NONE;
   char_type         line_bank [2][LINE_BUF];
   bit               shown_bank = 1'b0;
   int               saved_len = 0;

   rsp_beat_type   due_responses [$];
   script_row_type directed_script [$];
   rsp_beat_type   seen_rsp;
   rsp_beat_type   wanted_rsp;

   int  mismatches = 0;
   int  accepted_beats = 0;
   int  offered_items = 0;
   int  lines_saved = 0;
   int  cal_taken = 0;
   int  sens_taken = 0;
   int  reads_done = 0;
   bit  send_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   bit  pause_for_drain = 1'b0;

   function automatic int idle_cycles(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void advance_match(input bit is_max, inout int prog, inout bit hit,
                                         input char_type b);
      char_type want;
      want = is_max ? PAT_MAX[prog] : PAT_MIN[prog];
      if (want == b) begin
         prog++;
         if (prog == PAT_LEN) begin
            hit  = 1'b1;
            prog = 0;
         end
      end else begin
         prog = (b == CHAR_OPEN) ? 1 : 0;
      end
   endfunction

   function automatic rsp_beat_type compute_response(input req_beat_type b);
      rsp_beat_type r;
      bit           back;
      r = '0;
      case (b.kind)
         REQ_BYTE: begin
            back = ~shown_bank;
            if (b.rx_byte >= CHAR_SENS_LO && b.rx_byte <= CHAR_SENS_HI)
               held_cmd = CMD_SENS_1 + CMD_W'(b.rx_byte - CHAR_SENS_LO);
            line_bank[back][line_fill] = b.rx_byte;
            line_fill++;
            if (!nul_seen) begin
               if (b.rx_byte == CHAR_NUL) begin
                  nul_seen = 1'b1;
               end else begin
                  text_len++;
                  advance_match(1'b0, min_prog, min_hit, b.rx_byte);
                  advance_match(1'b1, max_prog, max_hit, b.rx_byte);
               end
            end
            if (b.rx_byte == CHAR_NEWLINE || line_fill >= LINE_BUF - 1) begin
               if (min_hit) begin
                  held_cmd = CMD_CAL_MIN;
               end else if (max_hit) begin
                  held_cmd = CMD_CAL_MAX;
               end else begin
                  shown_bank = back;
                  saved_len  = text_len;
                  lines_saved++;
               end
               min_prog  = 0;
               max_prog  = 0;
               min_hit   = 1'b0;
               max_hit   = 1'b0;
               nul_seen  = 1'b0;
               line_fill = 0;
               text_len  = 0;
            end
         end
         REQ_TAKE: begin
            r.command = held_cmd;
            if (held_cmd >= CMD_CAL_MIN) cal_taken++;
            else if (held_cmd != CMD_NONE) sens_taken++;
            held_cmd = CMD_NONE;
         end
         REQ_READ: begin
            reads_done++;
            if (b.read_index < saved_len) r.line_char = line_bank[shown_bank][b.read_index];
         end
         default: begin
         end
      endcase
      r.saved_length = SAVED_W'(saved_len);
      return r;
   endfunction

   function automatic char_type line_text_char();
      char_type c;
      if ($urandom_range(0, 7) == 0) c = char_type'($urandom_range(1, 255));
      else c = char_type'($urandom_range(8'h20, 8'h7E));
      if (c == CHAR_NEWLINE) c = CHAR_OPEN;
      return c;
   endfunction

   // offer one beat, wait for it to be taken, then queue what it should return
   task automatic offer(input req_beat_type b, input bit typed, input rsp_beat_type typed_rsp);
      int           gap;
      rsp_beat_type predicted;
      gap = idle_cycles(send_calm);
      if (gap > 0 || (pause_for_drain && due_responses.size() != 0)) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (pause_for_drain && due_responses.size() != 0) @(posedge clock);
      end
      pause_for_drain = 1'b0;
      req_if.valid      <= 1'b1;
      req_if.req_type   <= b.kind;
      req_if.rx_byte    <= b.rx_byte;
      req_if.read_index <= b.read_index;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      accepted_beats++;
      predicted = compute_response(b);
      due_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input char_type b,
                               input logic [IDX_W-1:0] idx);
      req_beat_type r;
      r.kind       = kind;
      r.rx_byte    = b;
      r.read_index = idx;
      if (kind != REQ_UNUSED) offered_items++;
      offer(r, 1'b0, '0);
   endtask

   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(REQ_BYTE, char_type'(s[i]), IDX_W'($urandom));
   endtask

   task automatic add_row(input logic [REQ_TYPE_W-1:0] kind, input char_type b,
                          input logic [IDX_W-1:0] idx, input bit typed,
                          input logic [CMD_W-1:0] cmd, input char_type ch,
                          input logic [SAVED_W-1:0] len);
      script_row_type row;
      row.req   = '{kind, b, idx};
      row.typed = typed;
      row.rsp   = '{cmd, ch, len};
      directed_script.push_back(row);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen_rsp.command      = rsp_if.command;
         seen_rsp.line_char    = rsp_if.line_char;
         seen_rsp.saved_length = rsp_if.saved_length;
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: command %0d char %02h length %0d",
                        seen_rsp.command, seen_rsp.line_char, seen_rsp.saved_length);
         end else begin
            wanted_rsp = due_responses.pop_front();
            if (seen_rsp.command !== wanted_rsp.command
                || seen_rsp.line_char !== wanted_rsp.line_char
                || seen_rsp.saved_length !== wanted_rsp.saved_length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected command %0d char %02h length %0d, got %0d %02h %0d",
                           wanted_rsp.command, wanted_rsp.line_char, wanted_rsp.saved_length,
                           seen_rsp.command, seen_rsp.line_char, seen_rsp.saved_length);
            end
         end
      end
   end

   // response side: random stalls, calm stretches and one long hold-off
   initial begin
      int  idle;
      int  steps;
      bit  hold_done;
      hold_done = 1'b0;
      steps = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         steps++;
         if (steps % 64 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         if (!hold_done && accepted_beats >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            idle = idle_cycles(rsp_calm);
            if (idle > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (idle) @(posedge clock);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      string both_text;
      int    pick;
      int    n;
      int    zpos;
      int    idx;
      bit    paused;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_BYTE;
      req_if.rx_byte    <= CHAR_NUL;
      req_if.read_index <= '0;
      paused = 1'b0;

      // both patterns with a sensitivity byte between them: min wins
      both_text = "<CAL:MAX>3<CAL:MIN>\n";
      add_row(REQ_TAKE, CHAR_NUL, '0, 1'b1, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_READ, CHAR_NUL, '0, 1'b1, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_UNUSED, 8'hFF, '1, 1'b1, CMD_NONE, CHAR_NUL, '0);
      for (int i = 0; i < both_text.len(); i++)
         add_row(REQ_BYTE, char_type'(both_text[i]), '0, 1'b0, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_TAKE, CHAR_NUL, '0, 1'b1, CMD_CAL_MIN, CHAR_NUL, '0);
      add_row(REQ_BYTE, 8'hFF, '1, 1'b0, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_BYTE, CHAR_NUL, '0, 1'b0, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_BYTE, CHAR_NEWLINE, '0, 1'b0, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_READ, CHAR_NUL, '0, 1'b0, CMD_NONE, CHAR_NUL, '0);
      add_row(REQ_READ, 8'hFF, '1, 1'b1, CMD_NONE, CHAR_NUL, 6'd1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i])
         offer(directed_script[i].req, directed_script[i].typed, directed_script[i].rsp);
      pause_for_drain = 1'b1;

      while (offered_items < RANDOM_ITEMS) begin
         send_calm = ($urandom_range(0, 5) == 0);
         if (!paused && accepted_beats >= PAUSE_AT) begin
            paused = 1'b1;
            pause_for_drain = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // calibration line, sometimes broken or hidden behind a zero byte
            repeat ($urandom_range(0, 3)) send_request(REQ_BYTE, line_text_char(), '1);
            if ($urandom_range(0, 5) == 0) send_request(REQ_BYTE, CHAR_NUL, '0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: offer_text("<CAL:MIN>");
               4, 5, 6:    offer_text("<CAL:MAX>");
               7:          offer_text("<CAL:MAX><CAL:MIN>");
               8:          offer_text("<CAL:M<CAL:MIN>");
               default:    offer_text("<CAL:MIX>");
            endcase
            if ($urandom_range(0, 3) == 0)
               send_request(REQ_BYTE, char_type'($urandom_range(CHAR_SENS_LO, CHAR_SENS_HI)),
                            '0);
            repeat ($urandom_range(0, 2)) send_request(REQ_BYTE, line_text_char(), '0);
            if ($urandom_range(0, 9) != 0) send_request(REQ_BYTE, CHAR_NEWLINE, '1);
            if ($urandom_range(0, 4) != 0) send_request(REQ_TAKE, char_type'($urandom), '1);
         end else if (pick < 60) begin
            // plain line that gets saved, then read back
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
            zpos = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : -1;
            for (int i = 0; i < n; i++)
               send_request(REQ_BYTE, (i == zpos) ? CHAR_NUL : line_text_char(),
                            IDX_W'($urandom));
            send_request(REQ_BYTE, CHAR_NEWLINE, IDX_W'($urandom));
            repeat ($urandom_range(1, 4)) begin
               idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n + 2);
               if (idx > 63) idx = 63;
               send_request(REQ_READ, char_type'($urandom), IDX_W'(idx));
            end
         end else if (pick < 75) begin
            if ($urandom_range(0, 3) != 0)
               send_request(REQ_BYTE, char_type'($urandom_range(CHAR_SENS_LO, CHAR_SENS_HI)),
                            IDX_W'($urandom));
            repeat ($urandom_range(1, 2)) send_request(REQ_TAKE, char_type'($urandom), '0);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6))
               send_request(REQ_TYPE_W'($urandom_range(0, 3)), char_type'($urandom_range(0, 255)),
                            IDX_W'($urandom_range(0, 63)));
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(REQ_READ, char_type'($urandom), IDX_W'($urandom_range(0, 63)));
         end
      end

      req_if.valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request beats: %0d lines saved, %0d reads of the saved line,",
               accepted_beats, lines_saved, reads_done);
      $display("%0d calibration and %0d sensitivity commands taken, %0d mismatches",
               cal_taken, sens_taken, mismatches);
      if (mismatches == 0 && due_responses.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/ulcp_pkg.sv
rtl/ulcp_req_if.sv
rtl/ulcp_rsp_if.sv
rtl/ulcp_ram.sv
rtl/uart_line_command_parser_core.sv
dv/testbench.sv
